// ----- src/fcrp_pkg.sv -----
package fcrp_pkg;

    localparam int MaxDescriptors = 16;
    localparam int QueueDepth     = 4;
    localparam int PtrW           = $clog2(QueueDepth);
    localparam int LvlW           = $clog2(QueueDepth + 1);

    localparam logic [8:0] LenPos      = 9'd3;
    localparam logic [8:0] CurEndPos   = 9'd11;
    localparam logic [8:0] FirstFmtPos = 9'd12;
    localparam logic [8:0] PosMax      = 9'd511;
    localparam logic [2:0] DescLastOff = 3'd7;

    typedef enum logic [1:0] {
        KIND_CURRENT = 2'd0,
        KIND_FORMAT  = 2'd1,
        KIND_END     = 2'd2
    } record_kind_t;

    typedef struct packed {
        record_kind_t kind;
        logic [31:0]  block_count;
        logic [5:0]   type_code;
        logic [23:0]  block_param;
        logic [4:0]   descriptor_index;
        logic         parse_ok;
        logic         last_result;
    } record_t;

    typedef struct packed {
        logic [1:0] count;
        record_t    first;
        record_t    second;
    } push_t;

    typedef struct packed {
        logic [LvlW-1:0] level;
        logic            room;
    } queue_status_t;

endpackage

// ----- src/fcrp_parser.sv -----
module fcrp_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output fcrp_pkg::push_t   push
);

    logic [8:0]  pos_reg,     pos_next;
    logic [7:0]  claimed_reg, claimed_next;
    logic [55:0] shift_reg,   shift_next;
    logic [4:0]  count_reg,   count_next;
    logic        seen_reg,    seen_next;

    logic [7:0]  claimed_eff;
    logic [8:0]  fmt_off;
    logic [5:0]  idx;
    logic        cur_hit;
    logic        fmt_hit;
    logic        has_desc;
    logic [7:0]  tbyte;
    fcrp_pkg::record_t desc_rec;
    fcrp_pkg::record_t end_rec;

    always_comb
    begin
        // byte 3 is usable on the same beat it arrives
        claimed_eff = (pos_reg == fcrp_pkg::LenPos) ? data_byte : claimed_reg;
        tbyte       = shift_reg[23:16];
        fmt_off     = pos_reg - fcrp_pkg::FirstFmtPos;
        idx         = fmt_off[8:3];

        cur_hit = (pos_reg == fcrp_pkg::CurEndPos) && (claimed_eff[7:3] != 5'd0);
        fmt_hit = (pos_reg >= fcrp_pkg::FirstFmtPos)
               && (fmt_off[2:0] == fcrp_pkg::DescLastOff)
               && seen_reg
               && (idx == {1'b0, count_reg})
               && (idx < 6'(fcrp_pkg::MaxDescriptors))
               && ({2'b00, claimed_eff[7:3]} >= ({1'b0, idx} + 7'd2));
        has_desc = cur_hit || fmt_hit;

        seen_next  = seen_reg || cur_hit;
        count_next = fmt_hit ? (idx[4:0] + 5'd1) : count_reg;

        desc_rec.kind             = cur_hit ? fcrp_pkg::KIND_CURRENT : fcrp_pkg::KIND_FORMAT;
        desc_rec.block_count      = shift_reg[55:24];
        desc_rec.type_code        = cur_hit ? {4'b0000, tbyte[1:0]} : tbyte[7:2];
        desc_rec.block_param      = {shift_reg[15:0], data_byte};
        desc_rec.descriptor_index = cur_hit ? 5'd0 : idx[4:0];
        desc_rec.parse_ok         = 1'b0;
        desc_rec.last_result      = 1'b0;

        end_rec.kind             = fcrp_pkg::KIND_END;
        end_rec.block_count      = 32'd0;
        end_rec.type_code        = 6'd0;
        end_rec.block_param      = 24'd0;
        end_rec.descriptor_index = seen_next ? count_next : 5'd0;
        end_rec.parse_ok         = seen_next;
        end_rec.last_result      = 1'b1;

        push.count  = fire ? ({1'b0, has_desc} + {1'b0, last_byte}) : 2'd0;
        push.first  = has_desc ? desc_rec : end_rec;
        push.second = end_rec;

        pos_next     = (pos_reg == fcrp_pkg::PosMax) ? pos_reg : (pos_reg + 9'd1);
        claimed_next = claimed_eff;
        shift_next   = {shift_reg[47:0], data_byte};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            claimed_reg <= '0;
            shift_reg   <= '0;
            count_reg   <= '0;
            seen_reg    <= 1'b0;
        end
        else if (fire)
        begin
            if (last_byte)
            begin
                // reply closed, start clean for the next one
                pos_reg     <= '0;
                claimed_reg <= '0;
                shift_reg   <= '0;
                count_reg   <= '0;
                seen_reg    <= 1'b0;
            end
            else
            begin
                pos_reg     <= pos_next;
                claimed_reg <= claimed_next;
                shift_reg   <= shift_next;
                count_reg   <= count_next;
                seen_reg    <= seen_next;
            end
        end
    end

endmodule

// ----- src/fcrp_queue.sv -----
module fcrp_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fcrp_pkg::push_t           push,
    input  logic                      pop,
    output fcrp_pkg::record_t         head,
    output fcrp_pkg::queue_status_t   status
);

    fcrp_pkg::record_t mem_reg [fcrp_pkg::QueueDepth];

    logic [fcrp_pkg::PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fcrp_pkg::PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fcrp_pkg::LvlW-1:0] level_reg,  level_next;
    logic [fcrp_pkg::PtrW-1:0] wr_ptr_second;

    always_comb
    begin
        wr_ptr_second = wr_ptr_reg + fcrp_pkg::PtrW'(1);
        wr_ptr_next   = wr_ptr_reg + fcrp_pkg::PtrW'(push.count);
        rd_ptr_next   = pop ? (rd_ptr_reg + fcrp_pkg::PtrW'(1)) : rd_ptr_reg;
        level_next    = level_reg + fcrp_pkg::LvlW'(push.count)
                      - fcrp_pkg::LvlW'(pop);

        head          = mem_reg[rd_ptr_reg];
        status.level  = level_reg;
        // a beat may bring two records
        status.room   = (level_reg <= fcrp_pkg::LvlW'(fcrp_pkg::QueueDepth - 2));
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_second] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ----- src/format_capacity_reply_parser_unit.sv -----
// a record completed by a beat is registered into the result queue and offered on the output from there
// throughput: one reply byte per cycle while in_ready is high; the final byte may yield two records
// input stalls only while the four-entry result queue holds three or more records
// reset (rst_n low, asynchronous) clears the byte position, length, shift and counts
// and empties the result queue; the block is ready as soon as reset releases
module format_capacity_reply_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  record_kind,
    output logic [31:0] block_count,
    output logic [5:0]  type_code,
    output logic [23:0] block_param,
    output logic [4:0]  descriptor_index,
    output logic        parse_ok,
    output logic        last_result
);

    fcrp_pkg::push_t         push;
    fcrp_pkg::record_t       head;
    fcrp_pkg::queue_status_t status;
    logic                    in_fire;
    logic                    out_fire;

    assign in_ready  = status.room;
    assign out_valid = (status.level != '0);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    fcrp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (in_fire),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push)
    );

    fcrp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (out_fire),
        .head   (head),
        .status (status)
    );

    assign record_kind      = head.kind;
    assign block_count      = head.block_count;
    assign type_code        = head.type_code;
    assign block_param      = head.block_param;
    assign descriptor_index = head.descriptor_index;
    assign parse_ok         = head.parse_ok;
    assign last_result      = head.last_result;

`ifndef ASSERT_OFF
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.level <= fcrp_pkg::LvlW'(fcrp_pkg::QueueDepth))
        else $error("result queue overflow");

    a_end_queued: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_byte |=> out_valid)
        else $error("final beat left no record");

    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_result |-> record_kind == fcrp_pkg::KIND_END)
        else $error("last_result on a descriptor record");

    a_ok_only_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_ok |-> last_result)
        else $error("parse_ok outside end record");
`endif

endmodule

// ----- dv/testbench.sv -----
module testbench;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  record_kind;
    logic [31:0] block_count;
    logic [5:0]  type_code;
    logic [23:0] block_param;
    logic [4:0]  descriptor_index;
    logic        parse_ok;
    logic        last_result;

    format_capacity_reply_parser_unit uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .record_kind      (record_kind),
        .block_count      (block_count),
        .type_code        (type_code),
        .block_param      (block_param),
        .descriptor_index (descriptor_index),
        .parse_ok         (parse_ok),
        .last_result      (last_result)
    );

    class capacity_scoreboard;
        logic [8:0]          pos;
        logic [7:0]          claim_len;
        logic [55:0]         tail_bytes;
        int                  fmt_done;
        bit                  cur_done;
        fcrp_pkg::record_t   expected_records[$];
        int                  failures;

        function new();
            failures = 0;
            clear();
        endfunction

        function void clear();
            pos        = '0;
            claim_len  = '0;
            tail_bytes = '0;
            fmt_done   = 0;
            cur_done   = 1'b0;
        endfunction

        // predicts the records that one accepted reply byte completes
        function void note_byte(logic [7:0] b, logic fin);
            fcrp_pkg::record_t r;
            int                at;
            int                slot;
            at = int'(pos);
            if (pos == fcrp_pkg::LenPos)
                claim_len = b;
            r             = '0;
            r.block_count = tail_bytes[55:24];
            r.block_param = {tail_bytes[15:0], b};
            if (pos == fcrp_pkg::CurEndPos)
            begin
                if (int'(claim_len) >= 8)
                begin
                    r.kind      = fcrp_pkg::KIND_CURRENT;
                    r.type_code = {4'b0, tail_bytes[17:16]};
                    expected_records.push_back(r);
                    cur_done = 1'b1;
                end
            end
            else if (at >= int'(fcrp_pkg::FirstFmtPos) &&
                     (at - int'(fcrp_pkg::FirstFmtPos)) % 8 == 7)
            begin
                slot = (at - int'(fcrp_pkg::FirstFmtPos)) / 8;
                // only in-order descriptors inside the floored claimed list, up to the cap
                if (cur_done && slot == fmt_done && slot < fcrp_pkg::MaxDescriptors &&
                    int'(claim_len) >= 8 * (slot + 2))
                begin
                    r.kind             = fcrp_pkg::KIND_FORMAT;
                    r.type_code        = tail_bytes[23:18];
                    r.descriptor_index = slot[4:0];
                    expected_records.push_back(r);
                    fmt_done = slot + 1;
                end
            end
            tail_bytes = {tail_bytes[47:0], b};
            if (pos != fcrp_pkg::PosMax)
                pos = pos + 9'd1;
            if (fin)
            begin
                r                  = '0;
                r.kind             = fcrp_pkg::KIND_END;
                r.descriptor_index = cur_done ? fmt_done[4:0] : 5'd0;
                r.parse_ok         = cur_done;
                r.last_result      = 1'b1;
                expected_records.push_back(r);
                clear();
            end
        endfunction

        function void check_record(fcrp_pkg::record_t got);
            fcrp_pkg::record_t want;
            bit                bad;
            if (expected_records.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected record: kind %0d count %0h type %0h param %0h idx %0d",
                             got.kind, got.block_count, got.type_code, got.block_param,
                             got.descriptor_index);
                return;
            end
            want = expected_records.pop_front();
            bad  = (got.kind !== want.kind) ||
                   (got.block_count !== want.block_count) ||
                   (got.type_code !== want.type_code) ||
                   (got.block_param !== want.block_param) ||
                   (got.descriptor_index !== want.descriptor_index) ||
                   (got.parse_ok !== want.parse_ok) ||
                   (got.last_result !== want.last_result);
            if (bad)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display({"mismatch expected: kind %0d count %0h type %0h param %0h",
                              " idx %0d ok %0d last %0d"},
                             want.kind, want.block_count, want.type_code, want.block_param,
                             want.descriptor_index, want.parse_ok, want.last_result);
                    $display({"         actual:   kind %0d count %0h type %0h param %0h",
                              " idx %0d ok %0d last %0d"},
                             got.kind, got.block_count, got.type_code, got.block_param,
                             got.descriptor_index, got.parse_ok, got.last_result);
                end
            end
        endfunction
    endclass

    capacity_scoreboard sb;
    fcrp_pkg::record_t  seen_rec;
    bit                 tx_burst = 1'b0;
    int                 bytes_sent = 0;
    int                 idle_cycles = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && in_ready === 1'b1)
                sb.note_byte(data_byte, last_byte);
            if (out_valid === 1'b1 && out_ready)
            begin
                seen_rec.kind             = fcrp_pkg::record_kind_t'(record_kind);
                seen_rec.block_count      = block_count;
                seen_rec.type_code        = type_code;
                seen_rec.block_param      = block_param;
                seen_rec.descriptor_index = descriptor_index;
                seen_rec.parse_ok         = parse_ok;
                seen_rec.last_result      = last_result;
                sb.check_record(seen_rec);
            end
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 1000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stalls with occasional stretches of none
    initial
    begin
        int stall;
        int rx_burst_left;
        out_ready     = 1'b0;
        rx_burst_left = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (rx_burst_left > 0)
            begin
                stall = 0;
                rx_burst_left--;
            end
            else
            begin
                stall = $urandom_range(0, 8);
                if ($urandom_range(0, 15) == 0)
                    rx_burst_left = $urandom_range(10, 40);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            @(negedge clk);
        end
    end

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        do @(posedge clk); while (in_ready !== 1'b1);
        @(negedge clk);
        bytes_sent++;
    endtask

    // fill: 0 random bytes, 1 all zeros, 2 all ones; byte 3, when sent, always carries the claim
    task automatic send_reply(input int claim, input int total, input int fill);
        logic [7:0] b;
        for (int i = 0; i < total; i++)
        begin
            if (i == int'(fcrp_pkg::LenPos))
                b = claim[7:0];
            else if (fill == 1)
                b = 8'h00;
            else if (fill == 2)
                b = 8'hFF;
            else
                b = $urandom_range(0, 255);
            send_byte(b, i == total - 1);
        end
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.expected_records.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int  shape;
        int  nf;
        int  claim;
        int  total;
        int  upper;
        bit  first;
        sb        = new();
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        last_byte = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // single-byte reply, short reply, current descriptor closing on the last byte
        send_reply(0, 1, 2);
        send_reply(16, 6, 1);
        send_reply(8, 12, 2);

        // full claim with more bytes than the cap and the position counter can hold
        tx_burst = 1'b1;
        send_reply(255, 520, 0);

        first = 1'b1;
        while (bytes_sent < 1200)
        begin
            if (first || $urandom_range(0, 7) == 0)
                hold_until_drained();
            first    = 1'b0;
            tx_burst = ($urandom_range(0, 3) == 0);
            shape    = $urandom_range(0, 9);
            nf       = $urandom_range(0, 4);
            unique case (shape)
                6:
                begin
                    // over-claimed: reply ends early, maybe mid descriptor
                    claim = $urandom_range(8, 255);
                    upper = (claim + 3 > 60) ? 60 : claim + 3;
                    send_reply(claim, $urandom_range(5, upper), 0);
                end
                7:
                begin
                    claim = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255);
                    send_reply(claim, $urandom_range(1, 40), 0);
                end
                8:
                begin
                    // length not a multiple of a descriptor, trailing bytes past the list
                    claim = 8 * (1 + nf) + $urandom_range(1, 7);
                    total = 4 + claim + $urandom_range(0, 20);
                    send_reply(claim, total, 0);
                end
                9:
                begin
                    claim = 8 * (1 + nf);
                    send_reply(claim, 4 + claim, $urandom_range(1, 2));
                end
                default:
                begin
                    claim = 8 * (1 + nf);
                    send_reply(claim, 4 + claim, 0);
                end
            endcase
        end
        in_valid <= 1'b0;

        while (sb.expected_records.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.failures == 0 && sb.expected_records.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
